>>> rtl/serial_loaded_prg_bank_mapper_core_macros.svh
// Assertion helpers shared by the mapper RTL.
`ifndef SERIAL_LOADED_PRG_BANK_MAPPER_CORE_MACROS_SVH
`define SERIAL_LOADED_PRG_BANK_MAPPER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLPBM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("slpbm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLPBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("slpbm: next-cycle check failed");

`endif

>>> rtl/slpbm_pkg.sv
package slpbm_pkg;

  // Bus access kinds
  typedef enum logic [1:0] {
    FUNC_CPU_READ  = 2'd0,
    FUNC_CPU_WRITE = 2'd1,
    FUNC_PPU_READ  = 2'd2,
    FUNC_PPU_WRITE = 2'd3
  } func_e;

  // Result routing
  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_PRG  = 2'd1,
    TGT_CHR  = 2'd2,
    TGT_ZERO = 2'd3
  } target_e;

  // Serial register select (address bits 14:13)
  typedef enum logic [1:0] {
    SEL_CONTROL = 2'd0,
    SEL_CHR0    = 2'd1,
    SEL_CHR1    = 2'd2,
    SEL_PRG     = 2'd3
  } serial_sel_e;

  // PRG modes (control bits 3:2)
  typedef enum logic [1:0] {
    PRG_MODE_32K_A     = 2'd0,
    PRG_MODE_32K_B     = 2'd1,
    PRG_MODE_FIX_FIRST = 2'd2,
    PRG_MODE_FIX_LAST  = 2'd3
  } prg_mode_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_PRG_BANK_COUNT  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_CHR_ROM_PRESENT = 1'b1;
  localparam int unsigned CfgDataW = 5;

  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned RomAddrW = 18;
  localparam int unsigned BankW    = 4;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned OffsetW  = 14;

  localparam logic [ShiftW-1:0] SHIFT_RESET   = 5'h10;
  localparam logic [ShiftW-1:0] CONTROL_RESET = 5'h0C;
  localparam logic [ShiftW-1:0] PRG_MODE_BITS = 5'h0C;
  localparam logic [BankW-1:0]  BANK32_MASK   = 4'hE;
  localparam logic [AddrW-1:0]  CHR_LAST_ADDR = 16'h1FFF;
  localparam logic [CfgDataW-1:0] BANK_COUNT_RESET = 5'd16;

  // Mapper registers as seen by the address map
  typedef struct packed {
    logic [ShiftW-1:0] control;
    logic [BankW-1:0]  prg_bank;
  } map_state_t;

  // Serial port write request
  typedef struct packed {
    logic              en;
    logic [1:0]        sel;
    logic [DataW-1:0]  data;
  } serial_cmd_t;

endpackage

>>> rtl/serial_loaded_prg_bank_mapper_core.sv
// Two register stages, the input register and the result register; an access
// is registered in the first, then in the second, and can stall in either.
// Throughput: one access per cycle while the result side does not stall; the
// input register refills while a result waits under stall.
// Reset (rst_ni low, asynchronous): pipeline empty, serial port holds only
// its marker, control 0x0C, PRG bank 0, bank count 16, CHR ROM present.
`include "serial_loaded_prg_bank_mapper_core_macros.svh"

module serial_loaded_prg_bank_mapper_core import slpbm_pkg::*; #(
  parameter int unsigned MAX_PRG_BANKS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // access in
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           func_i,
  input  logic [AddrW-1:0]     address_i,
  input  logic [DataW-1:0]     write_data_i,
  // result out
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 claimed_o,
  output logic [1:0]           target_o,
  output logic [RomAddrW-1:0]  rom_address_o
);

  logic                in_valid_q;
  logic [1:0]          func_q;
  logic [AddrW-1:0]    address_q;
  logic [DataW-1:0]    write_data_q;
  logic                out_valid_q;
  logic                claimed_q;
  logic [1:0]          target_q;
  logic [RomAddrW-1:0] rom_address_q;
  logic [CfgDataW-1:0] prg_bank_count_q;
  logic                chr_rom_present_q;

  logic                out_adv;
  logic                fire;
  logic                claimed_d;
  logic [1:0]          target_d;
  logic [RomAddrW-1:0] rom_address_d;
  serial_cmd_t         cmd;
  map_state_t          map_state;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_adv;
  assign in_stall_o = in_valid_q && !out_adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_bank_count_q  <= BANK_COUNT_RESET;
      chr_rom_present_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PRG_BANK_COUNT:  prg_bank_count_q  <= cfg_data_i;
        CFG_CHR_ROM_PRESENT: chr_rom_present_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      func_q       <= func_i;
      address_q    <= address_i;
      write_data_q <= write_data_i;
    end
  end

  slpbm_map #(
    .MAX_PRG_BANKS(MAX_PRG_BANKS)
  ) u_map (
    .act_i             (fire),
    .func_i            (func_q),
    .address_i         (address_q),
    .write_data_i      (write_data_q),
    .state_i           (map_state),
    .prg_bank_count_i  (prg_bank_count_q),
    .chr_rom_present_i (chr_rom_present_q),
    .cmd_o             (cmd),
    .claimed_o         (claimed_d),
    .target_o          (target_d),
    .rom_address_o     (rom_address_d)
  );

  slpbm_serial u_serial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .state_o (map_state)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      claimed_q     <= claimed_d;
      target_q      <= target_d;
      rom_address_q <= rom_address_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign claimed_o     = claimed_q;
  assign target_o      = target_q;
  assign rom_address_o = rom_address_q;

  // Any routed result belongs to a claimed access
  `SLPBM_ASSERT_IMPL(a_target_claimed, clk_i, rst_ni, out_valid_o && target_o != TGT_NONE,
                     claimed_o)
  // No ROM read means a zero address
  `SLPBM_ASSERT_IMPL(a_rom_zero, clk_i, rst_ni,
                     out_valid_o && (target_o == TGT_NONE || target_o == TGT_ZERO),
                     rom_address_o == '0)
  // A held access in the input register is not dropped
  `SLPBM_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_q && !out_adv,
                     in_valid_q && $stable(address_q) && $stable(func_q))

endmodule

>>> rtl/slpbm_serial.sv
`include "serial_loaded_prg_bank_mapper_core_macros.svh"

module slpbm_serial import slpbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  serial_cmd_t cmd_i,
  output map_state_t  state_o
);

  logic [ShiftW-1:0] shift_q, shift_d;
  logic [ShiftW-1:0] control_q, control_d;
  logic [BankW-1:0]  prg_bank_q, prg_bank_d;
  logic [ShiftW-1:0] shifted;

  assign shifted = {cmd_i.data[0], shift_q[ShiftW-1:1]};

  // Serial load: bit 7 resets the port, the fifth bit commits
  always_comb begin
    shift_d    = shift_q;
    control_d  = control_q;
    prg_bank_d = prg_bank_q;
    if (cmd_i.en) begin
      if (cmd_i.data[DataW-1]) begin
        shift_d   = SHIFT_RESET;
        control_d = control_q | PRG_MODE_BITS;
      end else if (shift_q[0]) begin
        shift_d = SHIFT_RESET;
        case (serial_sel_e'(cmd_i.sel))
          SEL_CONTROL: control_d  = shifted;
          SEL_PRG:     prg_bank_d = shifted[BankW-1:0];
          default:     ;
        endcase
      end else begin
        shift_d = shifted;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q    <= SHIFT_RESET;
      control_q  <= CONTROL_RESET;
      prg_bank_q <= '0;
    end else begin
      shift_q    <= shift_d;
      control_q  <= control_d;
      prg_bank_q <= prg_bank_d;
    end
  end

  assign state_o.control  = control_q;
  assign state_o.prg_bank = prg_bank_q;

  // The marker bit means the shift register is never empty
  `SLPBM_ASSERT_IMPL(a_shift_marker, clk_i, rst_ni, 1'b1, shift_q != '0)
  // A port reset leaves a fresh marker and PRG mode 3
  `SLPBM_ASSERT_NEXT(a_port_reset, clk_i, rst_ni, cmd_i.en && cmd_i.data[DataW-1],
                     shift_q == SHIFT_RESET && control_q[3:2] == PRG_MODE_FIX_LAST)
  // Registers only move on a serial transfer
  `SLPBM_ASSERT_NEXT(a_idle_hold, clk_i, rst_ni, !cmd_i.en,
                     $stable(control_q) && $stable(prg_bank_q))

endmodule

>>> rtl/slpbm_map.sv
module slpbm_map import slpbm_pkg::*; #(
  parameter int unsigned MAX_PRG_BANKS = 16
) (
  input  logic                 act_i,
  input  logic [1:0]           func_i,
  input  logic [AddrW-1:0]     address_i,
  input  logic [DataW-1:0]     write_data_i,
  input  map_state_t           state_i,
  input  logic [CfgDataW-1:0]  prg_bank_count_i,
  input  logic                 chr_rom_present_i,
  output serial_cmd_t          cmd_o,
  output logic                 claimed_o,
  output logic [1:0]           target_o,
  output logic [RomAddrW-1:0]  rom_address_o
);

  logic             high_half;
  logic [BankW-1:0] last_bank;
  logic [BankW-1:0] bank;
  logic [CfgDataW-1:0] count_clamped;

  assign high_half = address_i[OffsetW];

  // Last bank from the count clamped to 1..MAX_PRG_BANKS
  always_comb begin
    count_clamped = prg_bank_count_i;
    if (prg_bank_count_i == '0) begin
      count_clamped = CfgDataW'(1);
    end else if (prg_bank_count_i > CfgDataW'(MAX_PRG_BANKS)) begin
      count_clamped = CfgDataW'(MAX_PRG_BANKS);
    end
  end
  assign last_bank = BankW'(count_clamped - CfgDataW'(1));

  // PRG bank select by mode
  always_comb begin
    case (prg_mode_e'(state_i.control[3:2]))
      PRG_MODE_FIX_FIRST: bank = high_half ? state_i.prg_bank : '0;
      PRG_MODE_FIX_LAST:  bank = high_half ? last_bank : state_i.prg_bank;
      default:            bank = (state_i.prg_bank & BANK32_MASK) | {3'b000, high_half};
    endcase
  end

  // Access decode
  always_comb begin
    claimed_o     = 1'b0;
    target_o      = TGT_NONE;
    rom_address_o = '0;
    cmd_o.en      = 1'b0;
    cmd_o.sel     = address_i[14:13];
    cmd_o.data    = write_data_i;
    case (func_e'(func_i))
      FUNC_CPU_READ: begin
        if (address_i[AddrW-1]) begin
          claimed_o     = 1'b1;
          target_o      = TGT_PRG;
          rom_address_o = {bank, address_i[OffsetW-1:0]};
        end
      end
      FUNC_CPU_WRITE: begin
        if (address_i[AddrW-1]) begin
          claimed_o = 1'b1;
          cmd_o.en  = act_i;
        end
      end
      FUNC_PPU_READ: begin
        if (address_i <= CHR_LAST_ADDR) begin
          claimed_o = 1'b1;
          if (chr_rom_present_i) begin
            target_o      = TGT_CHR;
            rom_address_o = RomAddrW'(address_i);
          end else begin
            target_o = TGT_ZERO;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

>>> tb/serial_loaded_prg_bank_mapper_core_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the mapper, tracks its registers and compares every
// result transfer with the oldest predicted one.
module serial_loaded_prg_bank_mapper_core_checker import slpbm_pkg::*; #(
  parameter int unsigned MAX_PRG_BANKS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [1:0]           func_i,
  input  logic [AddrW-1:0]     address_i,
  input  logic [DataW-1:0]     write_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 claimed_i,
  input  logic [1:0]           target_i,
  input  logic [RomAddrW-1:0]  rom_address_i,
  output int                   mismatch_count_o,
  output int                   pending_o
);

  localparam logic [AddrW-1:0] PRG_BASE  = 16'h8000;
  localparam logic [AddrW-1:0] PRG_UPPER = 16'hC000;

  typedef struct packed {
    logic                claimed;
    target_e             target;
    logic [RomAddrW-1:0] rom_address;
  } bus_result_t;

  bus_result_t expected_results[$];

  // mirrored mapper state and configuration
  logic [ShiftW-1:0]   serial_q;
  logic [ShiftW-1:0]   control_q;
  logic [BankW-1:0]    prg_bank_q;
  logic [CfgDataW-1:0] bank_count_q;
  logic                chr_present_q;

  // last bank index, with the bank count clamped to what the mapper supports
  function automatic logic [BankW-1:0] last_bank(input logic [CfgDataW-1:0] count);
    int unsigned n;
    n = 32'(count);
    if (n < 1) n = 1;
    if (n > MAX_PRG_BANKS) n = MAX_PRG_BANKS;
    return BankW'(n - 1);
  endfunction

  function automatic logic [RomAddrW-1:0] prg_rom_address(input logic [AddrW-1:0] addr);
    logic [BankW-1:0] bank;
    logic             upper;
    prg_mode_e        mode;
    mode  = prg_mode_e'(control_q[3:2]);
    upper = (addr >= PRG_UPPER);
    case (mode)
      PRG_MODE_32K_A, PRG_MODE_32K_B: begin
        bank = (prg_bank_q & BANK32_MASK) + BankW'(upper);
      end
      PRG_MODE_FIX_FIRST: begin
        bank = upper ? prg_bank_q : '0;
      end
      default: begin
        bank = upper ? last_bank(bank_count_q) : prg_bank_q;
      end
    endcase
    // no wrap by bank count: banks past the ROM come out as they are
    return {bank, addr[OffsetW-1:0]};
  endfunction

  // serial port: bit 7 clears, else shift in bit 0; fifth bit commits
  task automatic serial_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    logic        done;
    serial_sel_e sel;
    if (data[7]) begin
      serial_q  = SHIFT_RESET;
      control_q = control_q | PRG_MODE_BITS;
    end else begin
      done     = serial_q[0];
      serial_q = {data[0], serial_q[ShiftW-1:1]};
      if (done) begin
        sel = serial_sel_e'(addr[14:13]);
        case (sel)
          SEL_CONTROL: control_q  = serial_q;
          SEL_PRG:     prg_bank_q = serial_q[BankW-1:0];
          default: ;  // CHR bank values are never used
        endcase
        serial_q = SHIFT_RESET;
      end
    end
  endtask

  task automatic predict_access(input func_e f, input logic [AddrW-1:0] addr,
                                input logic [DataW-1:0] data);
    bus_result_t r;
    r = '{claimed: 1'b0, target: TGT_NONE, rom_address: '0};
    case (f)
      FUNC_CPU_READ: begin
        if (addr >= PRG_BASE) begin
          r.claimed     = 1'b1;
          r.target      = TGT_PRG;
          r.rom_address = prg_rom_address(addr);
        end
      end
      FUNC_CPU_WRITE: begin
        if (addr >= PRG_BASE) begin
          r.claimed = 1'b1;
          serial_write(addr, data);
        end
      end
      FUNC_PPU_READ: begin
        if (addr <= CHR_LAST_ADDR) begin
          r.claimed = 1'b1;
          if (chr_present_q) begin
            r.target      = TGT_CHR;
            r.rom_address = RomAddrW'(addr);
          end else begin
            r.target = TGT_ZERO;
          end
        end
      end
      default: ;  // PPU writes are never claimed
    endcase
    expected_results.push_back(r);
  endtask

  // config writes, result compare, then prediction of the incoming transfer
  always @(posedge clk_i or negedge rst_ni) begin : track
    bus_result_t want;
    if (!rst_ni) begin
      serial_q      = SHIFT_RESET;
      control_q     = CONTROL_RESET;
      prg_bank_q    = '0;
      bank_count_q  = BANK_COUNT_RESET;
      chr_present_q = 1'b1;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PRG_BANK_COUNT:  bank_count_q  = cfg_data_i;
          CFG_CHR_ROM_PRESENT: chr_present_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no access outstanding");
          mismatch_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (claimed_i !== want.claimed) begin
            $error("claimed: expected %0d, got %0d", want.claimed, claimed_i);
            mismatch_count_o++;
          end
          if (target_i !== want.target) begin
            $error("target: expected %0d, got %0d", want.target, target_i);
            mismatch_count_o++;
          end
          if (rom_address_i !== want.rom_address) begin
            $error("rom_address: expected 0x%05h, got 0x%05h", want.rom_address,
                   rom_address_i);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_access(func_e'(func_i), address_i, write_data_i);
      end
    end
    pending_o = expected_results.size();
  end

endmodule

>>> tb/serial_loaded_prg_bank_mapper_core_test.sv
`timescale 1ns / 1ps

module serial_loaded_prg_bank_mapper_core_test;
  import slpbm_pkg::*;

  localparam int unsigned MAX_PRG_BANKS   = 16;
  localparam int unsigned IDLE_LIMIT      = 3000;
  localparam int unsigned ITEMS_PER_PHASE = 64;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned LONG_HOLD       = 150;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam logic [AddrW-1:0] PRG_BASE     = 16'h8000;
  localparam logic [DataW-1:0] SERIAL_CLEAR = 8'h80;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          func_i;
  logic [AddrW-1:0]    address_i;
  logic [DataW-1:0]    write_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                claimed_o;
  logic [1:0]          target_o;
  logic [RomAddrW-1:0] rom_address_o;

  int   mismatches;
  int   pending_results;
  int   sender_idle_pct    = 0;
  int   receiver_stall_pct = 0;
  logic long_hold_req      = 1'b0;
  int   claimed_sent       = 0;
  int   idle_cycles        = 0;

  serial_loaded_prg_bank_mapper_core #(
    .MAX_PRG_BANKS(MAX_PRG_BANKS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .claimed_o    (claimed_o),
    .target_o     (target_o),
    .rom_address_o(rom_address_o)
  );

  serial_loaded_prg_bank_mapper_core_checker #(
    .MAX_PRG_BANKS(MAX_PRG_BANKS)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .func_i          (func_i),
    .address_i       (address_i),
    .write_data_i    (write_data_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .claimed_i       (claimed_o),
    .target_i        (target_o),
    .rom_address_i   (rom_address_o),
    .mismatch_count_o(mismatches),
    .pending_o       (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side: random stall, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    bit hold_taken;
    hold_left   = 0;
    hold_taken  = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && long_hold_req && !hold_taken) begin
        hold_left  = LONG_HOLD;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  // watchdog: cycles without any transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // one access transfer; entered and left at a falling edge
  task automatic send_access(input func_e f, input logic [AddrW-1:0] a,
                             input logic [DataW-1:0] d);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    address_i    <= a;
    write_data_i <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    if (((f == FUNC_CPU_READ || f == FUNC_CPU_WRITE) && a[15]) ||
        (f == FUNC_PPU_READ && a <= CHR_LAST_ADDR)) begin
      claimed_sent++;
    end
  endtask

  // five serial writes, LSB first; the last address picks the register
  task automatic load_serial(input logic [AddrW-1:0] last_addr,
                             input logic [ShiftW-1:0] value);
    logic [DataW-1:0] d;
    for (int i = 0; i < ShiftW; i++) begin
      d = (DataW'($urandom) & 8'h7E) | DataW'(value[i]);
      send_access(FUNC_CPU_WRITE,
                  (i == ShiftW - 1) ? last_addr : (PRG_BASE | AddrW'($urandom)), d);
    end
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // mostly well-formed serial loads and mapped reads, some aborted loads and noise
  task automatic random_burst();
    int               pick;
    logic [AddrW-1:0] a;
    pick = $urandom_range(99);
    a    = PRG_BASE | AddrW'($urandom);
    if (pick < 35) begin
      if ($urandom_range(3) == 0) send_access(FUNC_CPU_WRITE, a, SERIAL_CLEAR | DataW'($urandom));
      load_serial(a, ShiftW'($urandom));
    end else if (pick < 48) begin
      repeat ($urandom_range(4, 1)) begin
        send_access(FUNC_CPU_WRITE, PRG_BASE | AddrW'($urandom), DataW'($urandom) & 8'h7F);
      end
      send_access(FUNC_CPU_WRITE, a, SERIAL_CLEAR | DataW'($urandom));
    end else if (pick < 76) begin
      send_access(FUNC_CPU_READ, a, DataW'($urandom));
    end else if (pick < 88) begin
      send_access(FUNC_PPU_READ, AddrW'($urandom_range(CHR_LAST_ADDR)), DataW'($urandom));
    end else begin
      send_access(func_e'($urandom_range(3)), AddrW'($urandom), DataW'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [CfgDataW-1:0] bank_count;
    logic                chr_present;
    bit                  paused;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_PRG_BANK_COUNT;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    func_i       = FUNC_CPU_READ;
    address_i    = '0;
    write_data_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: window edges, unclaimed accesses, serial loads and clears
    write_cfg(CFG_PRG_BANK_COUNT, 5'd16);
    write_cfg(CFG_CHR_ROM_PRESENT, 5'd1);
    send_access(FUNC_CPU_READ, PRG_BASE, 8'h00);
    send_access(FUNC_CPU_READ, 16'hFFFF, 8'hFF);
    send_access(FUNC_CPU_READ, 16'h7FFF, 8'h00);
    send_access(FUNC_PPU_READ, 16'h0000, 8'h00);
    send_access(FUNC_PPU_READ, CHR_LAST_ADDR, 8'h00);
    send_access(FUNC_PPU_READ, 16'h2000, 8'h00);
    send_access(FUNC_PPU_WRITE, 16'h1000, 8'hA5);
    send_access(FUNC_CPU_WRITE, 16'h7FFF, 8'hFF);
    send_access(FUNC_CPU_WRITE, PRG_BASE, SERIAL_CLEAR);
    load_serial(16'hFFFF, 5'h1F);
    send_access(FUNC_CPU_READ, PRG_BASE, 8'h00);
    load_serial(16'h9FFF, 5'h00);
    send_access(FUNC_CPU_READ, 16'hBFFF, 8'h00);
    send_access(FUNC_CPU_READ, 16'hC000, 8'h00);
    // clear in the middle of a load
    send_access(FUNC_CPU_WRITE, 16'hA000, 8'h01);
    send_access(FUNC_CPU_WRITE, 16'hC000, 8'h00);
    send_access(FUNC_CPU_WRITE, 16'hE000, 8'hFF);
    drain_results();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin bank_count = 5'd16; chr_present = 1'b1; end
        1: begin bank_count = 5'd1;  chr_present = 1'b0; end
        2: begin bank_count = 5'd0;  chr_present = 1'b1; end
        3: begin bank_count = 5'd31; chr_present = 1'b0; end
        4: begin bank_count = 5'd2;  chr_present = 1'b1; end
        5: begin bank_count = 5'd17; chr_present = 1'b1; end
        default: begin
          bank_count  = CfgDataW'($urandom_range(31));
          chr_present = 1'($urandom_range(1));
        end
      endcase
      write_cfg(CFG_PRG_BANK_COUNT, bank_count);
      write_cfg(CFG_CHR_ROM_PRESENT, CfgDataW'(chr_present));

      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 51; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 51; end
        default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase
      // receiver holds off while the sender keeps offering, filling the pipe
      if (phase == 2) long_hold_req = 1'b1;

      claimed_sent = 0;
      paused       = 1'b0;
      while (claimed_sent < ITEMS_PER_PHASE) begin
        random_burst();
        if (phase == 5 && !paused && claimed_sent >= ITEMS_PER_PHASE / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
      drain_results();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
